FILE: hw/rtl/asd_pkg.sv
package asd_pkg;

	localparam int ACCEL_W  = 16;
	localparam int MAG_W    = 16;
	localparam int STEP_W   = 24;
	localparam int PERIOD_W = 10;
	localparam int SQ_W     = 32;
	localparam int BW_W     = 13;
	localparam int THR_W    = 19;

	localparam logic [MAG_W-1:0]    AVG_RESET    = 16'd4505;
	localparam logic [BW_W-1:0]     BW_RESET     = 13'd450;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd100;

	// floor(v / 10) == (v * DIV10_MUL) >> DIV10_SHIFT for every 16-bit v
	localparam logic [MAG_W-1:0] DIV10_MUL   = 16'd52429;
	localparam int               DIV10_SHIFT = 19;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAG,
		ST_RING,
		ST_DIV,
		ST_BAND,
		ST_DECIDE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

FILE: hw/rtl/asd_channels.sv
interface asd_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [asd_pkg::ACCEL_W-1:0]   accel_x;
	logic signed [asd_pkg::ACCEL_W-1:0]   accel_y;
	logic signed [asd_pkg::ACCEL_W-1:0]   accel_z;

	modport source (output valid, accel_x, accel_y, accel_z, input ready);
	modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface asd_result_if;
	logic                          valid;
	logic                          ready;
	logic [asd_pkg::STEP_W-1:0]    step_total;
	logic                          step_detected;
	logic                          moving_state;
	logic [asd_pkg::MAG_W-1:0]     magnitude;

	modport source (output valid, step_total, step_detected, moving_state, magnitude,
		input ready);
	modport sink   (input valid, step_total, step_detected, moving_state, magnitude,
		output ready);
endinterface

FILE: hw/rtl/accel_step_detector.sv
// Step detector for a three-axis accelerometer, 4096 LSB per g.
// sample channel: one item per accelerometer reading (accel_x/y/z, signed).
// result channel: one item per sample with the running step_total, a
// step_detected flag for a rising step edge, the hysteresis moving_state and
// the sample magnitude (truncated square root of the summed squares).
// cfg_we/cfg_wdata write width_update_period, taken on any cycle with cfg_we
// high; write it only while no sample is in flight.
// One sample is in work at a time. It passes through the bit-serial
// magnitude unit (the squares, then the root), the hand-off and ring update,
// the bit-serial average divider, the band update and the decision, and the
// result is then loaded into the output register. The next sample is taken
// the cycle after the result is loaded.
// The result sits in an output register; a new sample is accepted while it
// waits, and a finished sample holds until the receiver takes the old one.
// Reset clears the counters, the ring fill and the step state; average and
// band width start at 1.1 g and 0.11 g. The ring memory is not cleared: only
// written entries are ever read.
module accel_step_detector #(
	parameter int WINDOW_DEPTH = 100
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [asd_pkg::PERIOD_W-1:0]   cfg_wdata,
	asd_sample_if.sink                     sample,
	asd_result_if.source                   result
);
	import asd_pkg::*;

	localparam int PTR_W  = $clog2(WINDOW_DEPTH);
	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W  = MAG_W + FILL_W;

	state_t              state_q, state_d;

	logic [PERIOD_W-1:0] period_q;
	logic [PTR_W-1:0]    wp_q;
	logic [FILL_W-1:0]   fill_q;
	logic [SUM_W-1:0]    sum_q;
	logic [MAG_W-1:0]    avg_q;
	logic [BW_W-1:0]     bw_q;
	logic [PERIOD_W-1:0] pc_q;
	logic                band_upd_q;
	logic                high_q;
	logic [STEP_W-1:0]   steps_q;
	logic [MAG_W-1:0]    mag_q;
	logic                rise_q;

	logic                out_valid_q;
	logic [STEP_W-1:0]   out_steps_q;
	logic                out_rise_q;
	logic                out_high_q;
	logic [MAG_W-1:0]    out_mag_q;

	logic                accept;
	logic                mag_start;
	logic                div_start;
	logic                ram_wr;
	logic                out_load;

	logic [MAG_W-1:0]    mag_w;
	unit_stat_t          mag_stat;
	unit_stat_t          div_stat;
	logic [SUM_W-1:0]    quo_w;
	logic [MAG_W-1:0]    old_mag;

	logic                ring_full;
	logic [SUM_W-1:0]    sum_d;
	logic [FILL_W-1:0]   fill_d;
	logic [PERIOD_W-1:0] pc_inc;
	logic [2*MAG_W-1:0]  div10_prod;
	logic signed [THR_W-1:0] upper, lower, mag_s;
	logic                high_d;

	// magnitude unit
	asd_mag_unit u_mag (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mag_start),
		.accel_x   (sample.accel_x),
		.accel_y   (sample.accel_y),
		.accel_z   (sample.accel_z),
		.magnitude (mag_w),
		.stat      (mag_stat)
	);

	// average divider
	asd_divider #(
		.DIVIDEND_W (SUM_W),
		.DIVISOR_W  (FILL_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_d),
		.divisor  (fill_d),
		.quotient (quo_w),
		.stat     (div_stat)
	);

	// magnitude window; the entry to be replaced is read at accept
	asd_ring_ram #(
		.DEPTH  (WINDOW_DEPTH),
		.DATA_W (MAG_W)
	) u_ring (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (wp_q),
		.rd_data (old_mag),
		.wr_en   (ram_wr),
		.wr_addr (wp_q),
		.wr_data (mag_q)
	);

	// ring sum and fill for this sample
	assign ring_full = fill_q == FILL_W'(WINDOW_DEPTH);
	always_comb begin
		if (ring_full) begin
			fill_d = fill_q;
			sum_d  = sum_q - SUM_W'(old_mag) + SUM_W'(mag_q);
		end else begin
			fill_d = fill_q + FILL_W'(1);
			sum_d  = sum_q + SUM_W'(mag_q);
		end
	end

	assign pc_inc     = pc_q + PERIOD_W'(1);
	assign div10_prod = avg_q * DIV10_MUL;

	// hysteresis thresholds
	assign upper  = THR_W'(avg_q) + THR_W'({bw_q, 1'b0});
	assign lower  = THR_W'(avg_q) - THR_W'({bw_q, 1'b0});
	assign mag_s  = THR_W'(mag_q);
	always_comb begin
		priority if (mag_s > upper) begin
			high_d = 1'b1;
		end else if (mag_s < lower) begin
			high_d = 1'b0;
		end else begin
			high_d = high_q;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state and strobes
	always_comb begin
		state_d      = state_q;
		sample.ready = 1'b0;
		accept       = 1'b0;
		mag_start    = 1'b0;
		div_start    = 1'b0;
		ram_wr       = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				sample.ready = 1'b1;
				if (sample.valid) begin
					accept    = 1'b1;
					mag_start = 1'b1;
					state_d   = ST_MAG;
				end
			end
			ST_MAG: begin
				if (mag_stat.done) begin
					state_d = ST_RING;
				end
			end
			ST_RING: begin
				ram_wr    = 1'b1;
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_BAND;
				end
			end
			ST_BAND: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RESET;
			wp_q        <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			avg_q       <= AVG_RESET;
			bw_q        <= BW_RESET;
			pc_q        <= '0;
			band_upd_q  <= 1'b0;
			high_q      <= 1'b0;
			steps_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			if (state_q == ST_RING) begin
				fill_q <= fill_d;
				sum_q  <= sum_d;
				wp_q   <= (wp_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
			end
			if (state_q == ST_DIV && div_stat.done) begin
				avg_q <= quo_w[MAG_W-1:0];
				if (pc_inc >= period_q) begin
					pc_q       <= '0;
					band_upd_q <= 1'b1;
				end else begin
					pc_q       <= pc_inc;
					band_upd_q <= 1'b0;
				end
			end
			if (state_q == ST_BAND && band_upd_q) begin
				bw_q <= div10_prod[DIV10_SHIFT +: BW_W];
			end
			if (state_q == ST_DECIDE) begin
				high_q <= high_d;
				if (!high_q && high_d) begin
					steps_q <= steps_q + STEP_W'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_MAG && mag_stat.done) begin
			mag_q <= mag_w;
		end
		if (state_q == ST_DECIDE) begin
			rise_q <= !high_q && high_d;
		end
		if (out_load) begin
			out_steps_q <= steps_q;
			out_rise_q  <= rise_q;
			out_high_q  <= high_q;
			out_mag_q   <= mag_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.step_total    = out_steps_q;
	assign result.step_detected = out_rise_q;
	assign result.moving_state  = out_high_q;
	assign result.magnitude     = out_mag_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW_DEPTH) && wp_q <= PTR_W'(WINDOW_DEPTH - 1))
		else $error("ring pointer or fill out of range");

	a_steps_only_on_decide: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_DECIDE |=> $stable(steps_q))
		else $error("step count moved outside the decision cycle");

	a_step_means_high: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.step_detected |-> result.moving_state)
		else $error("step flagged while state is low");

	a_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !mag_stat.busy && !div_stat.busy)
		else $error("unit still busy while waiting for a sample");

	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RING && !ring_full |=> fill_q == $past(fill_q) + FILL_W'(1))
		else $error("ring fill did not advance");

endmodule

FILE: hw/rtl/asd_mag_unit.sv
module asd_mag_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [asd_pkg::ACCEL_W-1:0] accel_x,
	input  logic signed [asd_pkg::ACCEL_W-1:0] accel_y,
	input  logic signed [asd_pkg::ACCEL_W-1:0] accel_z,
	output logic [asd_pkg::MAG_W-1:0]          magnitude,
	output asd_pkg::unit_stat_t                stat
);
	import asd_pkg::*;

	localparam int REM_W = MAG_W + 3;

	logic                busy_q;
	logic                done_q;
	logic                root_phase_q;
	logic [3:0]          cnt_q;
	logic [ACCEL_W-1:0]  ax_q, ay_q, az_q;
	logic [ACCEL_W-1:0]  bx_q, by_q, bz_q;
	logic [SQ_W-1:0]     acc_q;
	logic [REM_W-1:0]    rem_q;
	logic [MAG_W-1:0]    root_q;

	logic [ACCEL_W-1:0]  abs_x, abs_y, abs_z;
	logic [SQ_W-1:0]     acc_next;
	logic [REM_W-1:0]    rem_shift;
	logic [REM_W-1:0]    trial;
	logic                take;

	// magnitudes of the axes; the most negative value maps to 32768
	assign abs_x = accel_x[ACCEL_W-1] ? ACCEL_W'(-accel_x) : accel_x;
	assign abs_y = accel_y[ACCEL_W-1] ? ACCEL_W'(-accel_y) : accel_y;
	assign abs_z = accel_z[ACCEL_W-1] ? ACCEL_W'(-accel_z) : accel_z;

	// squares: one multiplier bit per axis per cycle, msb first
	assign acc_next = {acc_q[SQ_W-2:0], 1'b0}
		+ (bx_q[ACCEL_W-1] ? SQ_W'(ax_q) : '0)
		+ (by_q[ACCEL_W-1] ? SQ_W'(ay_q) : '0)
		+ (bz_q[ACCEL_W-1] ? SQ_W'(az_q) : '0);

	// root: two radicand bits per cycle
	assign rem_shift = {rem_q[REM_W-3:0], acc_q[SQ_W-1:SQ_W-2]};
	assign trial     = {1'b0, root_q, 2'b01};
	assign take      = rem_shift >= trial;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			done_q       <= 1'b0;
			root_phase_q <= 1'b0;
			cnt_q        <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q       <= 1'b1;
				root_phase_q <= 1'b0;
				cnt_q        <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					if (root_phase_q) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
					root_phase_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			ax_q   <= abs_x;
			ay_q   <= abs_y;
			az_q   <= abs_z;
			bx_q   <= abs_x;
			by_q   <= abs_y;
			bz_q   <= abs_z;
			acc_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			if (!root_phase_q) begin
				acc_q <= acc_next;
				bx_q  <= {bx_q[ACCEL_W-2:0], 1'b0};
				by_q  <= {by_q[ACCEL_W-2:0], 1'b0};
				bz_q  <= {bz_q[ACCEL_W-2:0], 1'b0};
			end else begin
				acc_q <= {acc_q[SQ_W-3:0], 2'b00};
				if (take) begin
					rem_q  <= rem_shift - trial;
					root_q <= {root_q[MAG_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_shift;
					root_q <= {root_q[MAG_W-2:0], 1'b0};
				end
			end
		end
	end

	assign magnitude = root_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("magnitude done while still busy");

	a_done_after_root: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(root_phase_q) && $past(cnt_q) == 4'd15)
		else $error("magnitude done without finishing the root");

	a_remainder_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q <= REM_W'({root_q, 1'b0}))
		else $error("root remainder above twice the root");

endmodule

FILE: hw/rtl/asd_divider.sv
module asd_divider #(
	parameter int DIVIDEND_W = 23,
	parameter int DIVISOR_W  = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic [DIVIDEND_W-1:0] quotient,
	output asd_pkg::unit_stat_t   stat
);
	import asd_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  d_q;

	logic [DIVISOR_W:0]    r_shift;
	logic                  ge;

	// restoring step: one quotient bit per cycle
	assign r_shift = {rem_q, quo_q[DIVIDEND_W-1]};
	assign ge      = r_shift >= {1'b0, d_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? DIVISOR_W'(r_shift - {1'b0, d_q}) : DIVISOR_W'(r_shift);
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !start && d_q != '0 |=> rem_q < d_q)
		else $error("divider remainder not below divisor");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !$past(done_q) && $past(busy_q))
		else $error("divider done without a finished run");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider busy while reporting done");

endmodule

FILE: hw/rtl/asd_ring_ram.sv
module asd_ring_ram #(
	parameter int DEPTH  = 100,
	parameter int DATA_W = 16
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data
);
	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
